@@ rtl/assert_macros.svh @@
// Assertion macros shared by the cluster word encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// Checks that a condition in one cycle is followed by a result in the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/pcwe_pkg.sv @@
// Types, codes and helper functions of the pixel cluster word encoder.
package pcwe_pkg;

   localparam int MAP_BITS     = 7;
   localparam int ADDR_BITS    = 10;
   localparam int ENCODER_BITS = 4;

   // Input item kinds.
   localparam logic [1:0] KIND_HIT   = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ABORT = 2'd2;

   // Result word kinds.
   localparam logic [1:0] WORD_SHORT   = 2'd0;
   localparam logic [1:0] WORD_LONG    = 2'd1;
   localparam logic [1:0] WORD_TRAILER = 2'd2;

   typedef struct packed {
      logic [1:0]              kind;
      logic [ENCODER_BITS-1:0] hit_encoder;
      logic [ADDR_BITS-1:0]    pixel_address;
   } req_type;

   typedef struct packed {
      logic [1:0]              word_kind;
      logic [ENCODER_BITS-1:0] word_encoder;
      logic [ADDR_BITS-1:0]    word_base;
      logic [MAP_BITS-1:0]     word_hitmap;
      logic                    last;
   } rsp_type;

   // Words produced by one item: count is 0, 1 or 2.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   // Builds the data word for a cluster: short if only the base pixel was hit.
   function automatic rsp_type cluster_word(logic [ENCODER_BITS-1:0] enc,
                                            logic [ADDR_BITS-1:0]    base,
                                            logic [MAP_BITS-1:0]     map);
      rsp_type w;
      w.word_encoder = enc;
      w.word_base    = base;
      w.last         = 1'b0;
      if (map == '0) begin
         w.word_kind   = WORD_SHORT;
         w.word_hitmap = '0;
      end else begin
         w.word_kind   = WORD_LONG;
         w.word_hitmap = map;
      end
      return w;
   endfunction

   function automatic rsp_type trailer_word();
      rsp_type w;
      w.word_kind    = WORD_TRAILER;
      w.word_encoder = '0;
      w.word_base    = '0;
      w.word_hitmap  = '0;
      w.last         = 1'b0;
      return w;
   endfunction

endpackage

@@ rtl/pcwe_in_stage.sv @@
// Input register of the cluster word encoder.
module pcwe_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pcwe_pkg::req_type req_word,
   input  logic             take,
   output logic             item_valid,
   output pcwe_pkg::req_type item
);

   logic              valid_ff, valid_in;
   pcwe_pkg::req_type item_ff,  item_in;

   // A new item can enter when the register is empty or is drained this cycle.
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         item_in  = req_word;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/pcwe_cluster.sv @@
// Cluster state and word building of the cluster word encoder.
`include "assert_macros.svh"
module pcwe_cluster (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   input  logic               take,
   input  pcwe_pkg::req_type  item,
   output pcwe_pkg::push_type push
);

   localparam int AB = pcwe_pkg::ADDR_BITS;
   localparam int MB = pcwe_pkg::MAP_BITS;
   localparam int EB = pcwe_pkg::ENCODER_BITS;

   logic          enable_ff, enable_in;
   logic          open_ff,   open_in;
   logic [EB-1:0] enc_ff,    enc_in;
   logic [AB-1:0] base_ff,   base_in;
   logic [MB-1:0] map_ff,    map_in;

   logic [AB-1:0] diff_lo;
   logic          in_window;
   logic          top_bit;
   logic [MB-1:0] map_hit;
   pcwe_pkg::rsp_type open_word;
   logic          take_end;
   logic          take_abort;

   assign take_end   = take && (item.kind == pcwe_pkg::KIND_END);
   assign take_abort = take && (item.kind == pcwe_pkg::KIND_ABORT);

   always_comb begin
      diff_lo   = item.pixel_address - base_ff;
      in_window = (item.hit_encoder == enc_ff) && (item.pixel_address > base_ff) &&
                  (diff_lo <= AB'(MB));
      top_bit   = (diff_lo == AB'(MB));
      for (int i = 0; i < MB; i++) begin
         map_hit[i] = map_ff[i] | (diff_lo == AB'(i + 1));
      end
      open_word = pcwe_pkg::cluster_word(enc_ff, base_ff, map_ff);
   end

   always_comb begin
      enable_in = csr_write_enable ? csr_write_data : enable_ff;
      open_in   = open_ff;
      enc_in    = enc_ff;
      base_in   = base_ff;
      map_in    = map_ff;
      push.count  = 2'd0;
      push.first  = open_word;
      push.second = pcwe_pkg::trailer_word();
      if (take) begin
         case (item.kind)
            pcwe_pkg::KIND_HIT: begin
               if (!enable_ff) begin
                  push.count = 2'd1;
                  push.first = pcwe_pkg::cluster_word(item.hit_encoder,
                                                      item.pixel_address, '0);
               end else if (!open_ff) begin
                  open_in = 1'b1;
                  enc_in  = item.hit_encoder;
                  base_in = item.pixel_address;
                  map_in  = '0;
               end else if (in_window) begin
                  map_in = map_hit;
                  if (top_bit) begin
                     // The top hitmap bit is set: send the cluster now.
                     push.count = 2'd1;
                     push.first = pcwe_pkg::cluster_word(enc_ff, base_ff, map_hit);
                     open_in    = 1'b0;
                  end
               end else begin
                  push.count = 2'd1;
                  open_in    = 1'b1;
                  enc_in     = item.hit_encoder;
                  base_in    = item.pixel_address;
                  map_in     = '0;
               end
            end
            pcwe_pkg::KIND_END: begin
               open_in = 1'b0;
               if (open_ff) begin
                  push.count = 2'd2;
               end else begin
                  push.count = 2'd1;
                  push.first = pcwe_pkg::trailer_word();
               end
            end
            pcwe_pkg::KIND_ABORT: begin
               open_in = 1'b0;
               map_in  = '0;
            end
            default: begin
            end
         endcase
      end
      push.first.last  = (push.count == 2'd1);
      push.second.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         open_ff   <= 1'b0;
         enc_ff    <= '0;
         base_ff   <= '0;
         map_ff    <= '0;
      end else begin
         enable_ff <= enable_in;
         open_ff   <= open_in;
         enc_ff    <= enc_in;
         base_ff   <= base_in;
         map_ff    <= map_in;
      end
   end

   `ASSERT_NEXT(a_end_closes, clock, reset, take_end, !open_ff)
   `ASSERT_NEXT(a_abort_clears, clock, reset, take_abort, !open_ff && map_ff == '0)
   `ASSERT_ALWAYS(a_pair_only_at_end, clock, reset, push.count != 2'd2 || (take_end && open_ff))

endmodule

@@ rtl/pcwe_out_queue.sv @@
// Result word queue of the cluster word encoder.
`include "assert_macros.svh"
module pcwe_out_queue (
   input  logic               clock,
   input  logic               reset,
   input  pcwe_pkg::push_type push,
   output logic               space_ok,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pcwe_pkg::rsp_type  rsp_word
);

   localparam int QDEPTH = 3;

   pcwe_pkg::rsp_type q_ff [QDEPTH];
   pcwe_pkg::rsp_type q_in [QDEPTH];
   logic [1:0] count_ff, count_in;
   logic [1:0] after_pop;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_word  = q_ff[0];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      after_pop = count_ff - 2'(pop);
      // Room for two words once this cycle's pop has happened.
      space_ok  = (after_pop <= 2'd1);
      for (int i = 0; i < QDEPTH - 1; i++) begin
         q_in[i] = pop ? q_ff[i + 1] : q_ff[i];
      end
      q_in[QDEPTH - 1] = q_ff[QDEPTH - 1];
      for (int i = 0; i < QDEPTH; i++) begin
         if (push.count != 2'd0 && after_pop == 2'(i)) begin
            q_in[i] = push.first;
         end
         if (push.count == 2'd2 && after_pop + 2'd1 == 2'(i)) begin
            q_in[i] = push.second;
         end
      end
      count_in = after_pop + push.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   `ASSERT_ALWAYS(a_no_overflow, clock, reset, push.count == 2'd0 || after_pop <= 2'd1)
   `ASSERT_NEXT(a_count_tracks, clock, reset, 1'b1, count_ff == $past(after_pop) + $past(push.count))

endmodule

@@ rtl/pixel_cluster_word_encoder.sv @@
// Top level of the pixel cluster word encoder.
//
// The block packs the pixel hits of one readout region into data words.
// Input words arrive on req_valid/req_ready/req_word: a hit (encoder id and
// pixel address, in rising address order), an end of region, or an abort.
// Result words leave on rsp_valid/rsp_ready/rsp_word: short words, long words
// with a hitmap of the pixels after the base, and a region trailer. The last
// flag marks the final word caused by one input word.
// Clustering is switched by csr_write_enable/csr_write_data; write it only
// while the block is idle.
// An accepted word waits in the input register until the queue has room for
// its words; the cluster logic handles it in a single pass, its results are
// registered in the output queue and offered on rsp_valid. One input word
// is taken every cycle while the queue has room; an end of region flushing
// a cluster yields two words. The single-pass cluster update sets the rate.
// When the receiver stalls, the three-entry output queue absorbs the words
// in flight and req_ready drops once it cannot take two more words.
// Synchronous reset empties both registers, closes any cluster and turns
// clustering on.
module pixel_cluster_word_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pcwe_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pcwe_pkg::rsp_type rsp_word,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);

   logic               item_valid;
   pcwe_pkg::req_type  item;
   logic               space_ok;
   logic               take;
   pcwe_pkg::push_type push;

   // The held item is processed as soon as the queue has room for its words.
   assign take = item_valid && space_ok;

   pcwe_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   pcwe_cluster u_cluster (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .take             (take),
      .item             (item),
      .push             (push)
   );

   pcwe_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

@@ sim/cluster_word_checker.sv @@
// Checker that predicts and compares the result words of the pixel cluster word encoder.
`timescale 1ns / 100ps
module cluster_word_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  pcwe_pkg::req_type req_word,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  pcwe_pkg::rsp_type rsp_word,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   output int                error_count,
   output int                words_pending
);

   // Shadow copy of the clustering switch and of the open cluster.
   logic                              clustering_on = 1'b1;
   logic                              open_flag     = 1'b0;
   logic [pcwe_pkg::ENCODER_BITS-1:0] open_encoder  = '0;
   logic [pcwe_pkg::ADDR_BITS-1:0]    open_base     = '0;
   logic [pcwe_pkg::MAP_BITS-1:0]     open_map      = '0;

   pcwe_pkg::rsp_type words_due[$];
   pcwe_pkg::rsp_type item_words[$];
   int      mismatches = 0;
   int      due_count  = 0;

   assign error_count   = mismatches;
   assign words_pending = due_count;

   function automatic pcwe_pkg::rsp_type data_word(
         logic [pcwe_pkg::ENCODER_BITS-1:0] enc,
         logic [pcwe_pkg::ADDR_BITS-1:0]    base,
         logic [pcwe_pkg::MAP_BITS-1:0]     map);
      pcwe_pkg::rsp_type w;
      w.word_kind    = (map == '0) ? pcwe_pkg::WORD_SHORT : pcwe_pkg::WORD_LONG;
      w.word_encoder = enc;
      w.word_base    = base;
      w.word_hitmap  = map;
      w.last         = 1'b0;
      return w;
   endfunction

   task automatic close_cluster();
      item_words.insert(item_words.size(), data_word(open_encoder, open_base, open_map));
      open_flag = 1'b0;
   endtask

   task automatic start_cluster(input pcwe_pkg::req_type w);
      open_flag    = 1'b1;
      open_encoder = w.hit_encoder;
      open_base    = w.pixel_address;
      open_map     = '0;
   endtask

   // Works out the words that one accepted input word causes.
   task automatic predict_words(input pcwe_pkg::req_type w);
      pcwe_pkg::rsp_type trailer;
      int      offset;
      item_words.delete();
      offset = int'(w.pixel_address) - int'(open_base);
      case (w.kind)
         pcwe_pkg::KIND_HIT: begin
            if (!clustering_on) begin
               item_words.insert(item_words.size(),
                                 data_word(w.hit_encoder, w.pixel_address, '0));
            end else if (!open_flag) begin
               start_cluster(w);
            end else if (w.hit_encoder == open_encoder && offset >= 1 &&
                         offset <= pcwe_pkg::MAP_BITS) begin
               open_map[offset - 1] = 1'b1;
               if (offset == pcwe_pkg::MAP_BITS) close_cluster();
            end else begin
               close_cluster();
               start_cluster(w);
            end
         end
         pcwe_pkg::KIND_END: begin
            if (open_flag) close_cluster();
            trailer = '0;
            trailer.word_kind = pcwe_pkg::WORD_TRAILER;
            item_words.insert(item_words.size(), trailer);
         end
         pcwe_pkg::KIND_ABORT: begin
            open_flag = 1'b0;
            open_map  = '0;
         end
         default: ;
      endcase
      if (item_words.size() > 0) item_words[item_words.size() - 1].last = 1'b1;
      foreach (item_words[i]) words_due.insert(words_due.size(), item_words[i]);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      pcwe_pkg::rsp_type want;
      if (reset) begin
         clustering_on = 1'b1;
         open_flag     = 1'b0;
         open_encoder  = '0;
         open_base     = '0;
         open_map      = '0;
         words_due.delete();
      end else begin
         // A result can never belong to an input accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (words_due.size() == 0) begin
               $display("%0t ns: unexpected word, expected none, actual %h", $time, rsp_word);
               mismatches++;
            end else begin
               want = words_due.pop_front();
               check_field("word_kind", want.word_kind, rsp_word.word_kind);
               check_field("word_encoder", want.word_encoder, rsp_word.word_encoder);
               check_field("word_base", want.word_base, rsp_word.word_base);
               check_field("word_hitmap", want.word_hitmap, rsp_word.word_hitmap);
               check_field("last", want.last, rsp_word.last);
            end
         end
         if (csr_write_enable) clustering_on = csr_write_data;
         if (req_valid && req_ready) predict_words(req_word);
      end
      due_count = words_due.size();
   end

endmodule

@@ sim/testbench.sv @@
// Testbench top for the pixel cluster word encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

   // The one input kind that the block must ignore.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam int ITEMS_PER_PHASE = 90;
   localparam int PHASE_COUNT     = 8;
   // Input register plus the three-entry output queue, with some margin.
   localparam int SETTLE_CYCLES   = 8;
   localparam int CYCLE_LIMIT     = 400000;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   pcwe_pkg::req_type req_word         = '0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   pcwe_pkg::rsp_type rsp_word;
   logic              csr_write_enable = 1'b0;
   logic              csr_write_data   = 1'b0;

   int error_count;
   int words_pending;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int cycle_count   = 0;
   int items_sent    = 0;

   // Idling plan per phase: none, sender only, receiver only, then both lightly.
   int idle_plan[4]  = '{0, 86, 0, 14};
   int stall_plan[4] = '{0, 0, 86, 14};

   pixel_cluster_word_encoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   cluster_word_checker word_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .words_pending    (words_pending)
   );

   always #6 clock = ~clock;

   // The receiver decides anew at every edge whether it takes a word.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic pcwe_pkg::req_type make_req(logic [1:0] kind, int enc, int addr);
      pcwe_pkg::req_type w;
      w.kind          = kind;
      w.hit_encoder   = enc[pcwe_pkg::ENCODER_BITS-1:0];
      w.pixel_address = addr[pcwe_pkg::ADDR_BITS-1:0];
      return w;
   endfunction

   // Offers one word and returns at the edge where it is accepted. A random
   // gap comes first; valid is only lowered when such a gap is taken, so a
   // back-to-back word keeps valid high without a glitch in the same step.
   task automatic send_word(input pcwe_pkg::req_type w);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      if (w.kind != KIND_UNUSED) items_sent++;
   endtask

   // Stops sending and waits until every predicted word has come out. Some
   // hits cause no word at all, so a few more cycles pass before the block
   // counts as idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Must be called at a clock edge while the block is idle.
   task automatic write_clustering(input logic on);
      csr_write_enable <= 1'b1;
      csr_write_data   <= on;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One region: hits in mostly rising address order, with small steps so
   // that clusters form. A share of the steps jumps past the hitmap, repeats
   // the last address or goes backwards, and the encoder changes now and
   // then. The region closes with an end of region, an abort, or stray
   // unused-kind noise before the end.
   task automatic send_region();
      int enc;
      int addr;
      int hits;
      int step;
      int r;
      enc  = $urandom_range(15);
      addr = $urandom_range(1023);
      if ($urandom_range(9) == 0) addr = 1023 - $urandom_range(12);
      hits = $urandom_range(12);
      for (int i = 0; i < hits; i++) begin
         send_word(make_req(pcwe_pkg::KIND_HIT, enc, addr));
         r = $urandom_range(99);
         if (r < 70) step = $urandom_range(pcwe_pkg::MAP_BITS, 1);
         else if (r < 85) step = $urandom_range(40, pcwe_pkg::MAP_BITS + 1);
         else if (r < 92) step = 0;
         else step = -int'($urandom_range(addr, 0));
         if ($urandom_range(99) < 15) enc = $urandom_range(15);
         addr += step;
         // Addresses do not wrap; the region simply stops at the top.
         if (addr > 1023) break;
      end
      r = $urandom_range(99);
      if (r < 10) begin
         send_word(make_req(pcwe_pkg::KIND_ABORT, $urandom_range(15), $urandom_range(1023)));
      end else begin
         if (r < 18)
            send_word(make_req(KIND_UNUSED, $urandom_range(15), $urandom_range(1023)));
         send_word(make_req(pcwe_pkg::KIND_END, $urandom_range(15), $urandom_range(1023)));
      end
   endtask

   initial begin
      int target;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, clustering on.
      write_clustering(1'b1);
      // A cluster filled up to the top hitmap bit goes out as a long word at once.
      send_word(make_req(pcwe_pkg::KIND_HIT, 0, 0));
      send_word(make_req(pcwe_pkg::KIND_HIT, 0, 1));
      send_word(make_req(pcwe_pkg::KIND_HIT, 0, 3));
      send_word(make_req(pcwe_pkg::KIND_HIT, 0, 7));
      // A repeated address is not above the base: the old cluster goes out as
      // a short word and a new one opens; the end flushes it before the trailer.
      send_word(make_req(pcwe_pkg::KIND_HIT, 15, 1023));
      send_word(make_req(pcwe_pkg::KIND_HIT, 15, 1023));
      send_word(make_req(pcwe_pkg::KIND_END, 0, 0));
      // Near the top of the address range the window must not wrap.
      send_word(make_req(pcwe_pkg::KIND_HIT, 5, 1020));
      send_word(make_req(pcwe_pkg::KIND_HIT, 5, 1023));
      send_word(make_req(pcwe_pkg::KIND_END, 15, 1023));
      // A different encoder and a jump past the window both close the cluster;
      // the abort then drops the open one, so the end gives a lone trailer.
      send_word(make_req(pcwe_pkg::KIND_HIT, 3, 100));
      send_word(make_req(pcwe_pkg::KIND_HIT, 4, 101));
      send_word(make_req(pcwe_pkg::KIND_HIT, 4, 109));
      send_word(make_req(pcwe_pkg::KIND_ABORT, 9, 682));
      send_word(make_req(pcwe_pkg::KIND_END, 6, 341));
      // The unused kind must be ignored entirely.
      send_word(make_req(KIND_UNUSED, 15, 1023));
      send_word(make_req(pcwe_pkg::KIND_HIT, 2, 500));
      send_word(make_req(pcwe_pkg::KIND_HIT, 2, 506));
      send_word(make_req(pcwe_pkg::KIND_END, 0, 0));
      // Leave a cluster open, then switch clustering off: hits give short
      // words right away and the end still flushes the old cluster.
      send_word(make_req(pcwe_pkg::KIND_HIT, 10, 682));
      wait_idle();
      write_clustering(1'b0);
      send_word(make_req(pcwe_pkg::KIND_HIT, 7, 341));
      send_word(make_req(pcwe_pkg::KIND_HIT, 0, 0));
      send_word(make_req(pcwe_pkg::KIND_END, 0, 0));
      send_word(make_req(pcwe_pkg::KIND_END, 0, 0));

      // Random part: every idling plan is used twice, and clustering is off
      // in two of the phases. Each phase starts from a drained block.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         send_idle_pct = idle_plan[phase % 4];
         stall_pct     = stall_plan[phase % 4];
         wait_idle();
         write_clustering(phase != 2 && phase != 5);
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) send_region();
      end

      stall_pct = 0;
      wait_idle();
      if (error_count == 0 && words_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
